FILE: hdl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Codes and fixed constants of the timer table: command modes, result kinds,
// the empty-deadline marker and the cap on expiry events per tick.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_ALLOC = 3'd1;
  localparam logic [2:0] MODE_FREE  = 3'd2;
  localparam logic [2:0] MODE_INIT  = 3'd3;
  localparam logic [2:0] MODE_SET   = 3'd4;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = 6;

endpackage

FILE: hdl/multi_timer_table.sv
// ----------------------------------------------------------------------------
// multi_timer_table
// Table of one-shot timers driven by a tick, with allocation, free, init and
// set-timeout commands and in-order expiry events.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low. The
//   mode field selects tick, allocate, free, init or set timeout.
//   Free, init, set timeout, unknown modes and a tick that stays short of the
//   earliest deadline finish in the accept cycle and leave busy low, so a new
//   command may follow at once.
//   Allocate walks the in-use bits one entry per cycle until it finds an
//   unused entry or reaches the last one, then gives one answer with kind 0.
//   A tick that reaches the earliest deadline scans the table memory at one
//   entry per cycle through its single read port, busy until the scan and
//   its flush step are done. Expiry events (kind 1) come out in index order,
//   last set on the final one; at most 32 per tick.
//   Each result is shown for exactly one cycle, marked by strobe; the
//   receiver cannot stall the block, so no result is ever held back.
//   Reset clears the in-use bits (all entries unused), zeroes the tick count
//   and sets the earliest deadline to all ones. Deadline, data and channel
//   storage needs no clearing pass.
// ----------------------------------------------------------------------------
module multi_timer_table #(
  parameter int NUM_TIMERS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  mode,
  input  logic [4:0]  timer_index,
  input  logic [31:0] timeout,
  input  logic [7:0]  payload,
  input  logic [3:0]  channel,
  output logic        busy,
  output logic        strobe,
  output logic        kind,
  output logic [4:0]  entry,
  output logic        alloc_ok,
  output logic [7:0]  event_data,
  output logic [3:0]  event_channel,
  output logic        last
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int PW = IW + 1;
  localparam logic [PW-1:0] LAST_PTR = PW'(NUM_TIMERS - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  // An entry whose live bit is clear is unused; stored status is one of these.
  localparam logic [1:0] ST_ALLOC   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;

  typedef enum logic [1:0] {S_IDLE, S_ALLOC, S_SCAN, S_FLUSH} state_t;

  state_t state;

  logic [33:0] mem_a [NUM_TIMERS];   // {status, deadline}
  logic [11:0] mem_b [NUM_TIMERS];   // {data, channel}

  logic [31:0]           tick_count;
  logic [31:0]           earliest;
  logic [NUM_TIMERS-1:0] live;
  logic [PW-1:0]         ptr;

  logic           ev_valid;
  logic           ev_live;
  logic [IW-1:0]  ev_idx;
  logic [1:0]     ev_status;
  logic [31:0]    ev_deadline;
  logic [7:0]     ev_payload;
  logic [3:0]     ev_channel;

  logic [mtt_pkg::RES_CNT_W-1:0] n_events;
  logic           pend;
  logic [IW-1:0]  pend_idx;
  logic [7:0]     pend_payload;
  logic [3:0]     pend_channel;

  logic           accept;
  logic [6:0]     idx_ext;
  logic           idx_ok;
  logic [IW-1:0]  idx_addr;
  logic [31:0]    tick_next;
  logic [31:0]    set_deadline;
  logic           ptr_in;
  logic [IW-1:0]  ptr_addr;
  logic           ev_running;
  logic           ev_expire;
  logic           ev_end;
  logic           alloc_hit;

  logic           wr_a_en;
  logic [IW-1:0]  wr_a_addr;
  logic [33:0]    wr_a_data;
  logic           wr_b_en;

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign idx_ext      = {2'b00, timer_index};
  assign idx_ok       = (idx_ext < 7'(NUM_TIMERS));
  assign idx_addr     = idx_ext[IW-1:0];
  assign tick_next    = tick_count + 32'd1;
  assign set_deadline = tick_count + timeout;
  assign ptr_in       = (ptr < PW'(NUM_TIMERS));
  assign ptr_addr     = ptr[IW-1:0];

  assign ev_running = ev_valid && ev_live && (ev_status == ST_RUNNING);
  assign ev_expire  = ev_running && (ev_deadline <= tick_count) &&
                      (n_events < mtt_pkg::RES_CNT_W'(mtt_pkg::MAX_RESULTS));
  assign ev_end     = ev_valid && (ev_idx == LAST_IDX);
  assign alloc_hit  = (state == S_ALLOC) && !live[ptr_addr];

  assign wr_b_en = accept && (mode == mtt_pkg::MODE_INIT) && idx_ok;

  // Single write port of the status/deadline memory.
  always_comb begin
    wr_a_en   = 1'b0;
    wr_a_addr = idx_addr;
    wr_a_data = {ST_RUNNING, set_deadline};
    if (accept && (mode == mtt_pkg::MODE_SET) && idx_ok) begin
      wr_a_en = 1'b1;
    end else if (alloc_hit) begin
      wr_a_en   = 1'b1;
      wr_a_addr = ptr_addr;
      wr_a_data = {ST_ALLOC, 32'd0};
    end else if ((state == S_SCAN) && ev_expire) begin
      wr_a_en   = 1'b1;
      wr_a_addr = ev_idx;
      wr_a_data = {ST_ALLOC, ev_deadline};
    end
  end

  // The scan reads entry ptr while it writes back entry ptr - 1, so the two
  // never touch the same entry.
  always_ff @(posedge clk) begin
    if (wr_a_en) begin
      mem_a[wr_a_addr] <= wr_a_data;
    end
    if (wr_b_en) begin
      mem_b[idx_addr] <= {payload, channel};
    end
    if ((state == S_SCAN) && ptr_in) begin
      {ev_status, ev_deadline} <= mem_a[ptr_addr];
      {ev_payload, ev_channel} <= mem_b[ptr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= 32'd0;
      earliest   <= mtt_pkg::NO_DEADLINE;
      live       <= '0;
      ptr        <= '0;
      ev_valid   <= 1'b0;
      pend       <= 1'b0;
      n_events   <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              mtt_pkg::MODE_TICK: begin
                tick_count <= tick_next;
                if (earliest <= tick_next) begin
                  earliest <= mtt_pkg::NO_DEADLINE;
                  ptr      <= '0;
                  ev_valid <= 1'b0;
                  n_events <= '0;
                  pend     <= 1'b0;
                  state    <= S_SCAN;
                end
              end
              mtt_pkg::MODE_ALLOC: begin
                ptr   <= '0;
                state <= S_ALLOC;
              end
              mtt_pkg::MODE_FREE: begin
                if (idx_ok) begin
                  live[idx_addr] <= 1'b0;
                end
              end
              mtt_pkg::MODE_SET: begin
                if (idx_ok) begin
                  live[idx_addr] <= 1'b1;
                  if (set_deadline < earliest) begin
                    earliest <= set_deadline;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (alloc_hit || (ptr == LAST_PTR)) begin
            strobe        <= 1'b1;
            kind          <= mtt_pkg::KIND_ALLOC;
            entry         <= alloc_hit ? 5'(ptr_addr) : 5'd0;
            alloc_ok      <= alloc_hit;
            event_data    <= 8'd0;
            event_channel <= 4'd0;
            last          <= 1'b1;
            state         <= S_IDLE;
            if (alloc_hit) begin
              live[ptr_addr] <= 1'b1;
            end
          end else begin
            ptr <= ptr + PW'(1);
          end
        end
        S_SCAN: begin
          ev_valid <= ptr_in;
          ev_idx   <= ptr_addr;
          if (ptr_in) begin
            ev_live <= live[ptr_addr];
            ptr     <= ptr + PW'(1);
          end
          // Hold each event one step so the final one can carry last.
          if (ev_expire) begin
            n_events <= n_events + mtt_pkg::RES_CNT_W'(1);
            if (pend) begin
              strobe        <= 1'b1;
              kind          <= mtt_pkg::KIND_EXPIRY;
              entry         <= 5'(pend_idx);
              alloc_ok      <= 1'b0;
              event_data    <= pend_payload;
              event_channel <= pend_channel;
              last          <= 1'b0;
            end
            pend         <= 1'b1;
            pend_idx     <= ev_idx;
            pend_payload <= ev_payload;
            pend_channel <= ev_channel;
          end else if (ev_running && (ev_deadline < earliest)) begin
            earliest <= ev_deadline;
          end
          if (ev_end) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (pend) begin
            strobe        <= 1'b1;
            kind          <= mtt_pkg::KIND_EXPIRY;
            entry         <= 5'(pend_idx);
            alloc_ok      <= 1'b0;
            event_data    <= pend_payload;
            event_channel <= pend_channel;
            last          <= 1'b1;
          end
          pend  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/mtt_checker.sv
// ----------------------------------------------------------------------------
// mtt_checker
// Port-level checks of the timer table: allocation answers, expiry event
// framing and command acceptance.
// ----------------------------------------------------------------------------
module mtt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic [2:0]  mode,
  input logic        busy,
  input logic        strobe,
  input logic        kind,
  input logic [4:0]  entry,
  input logic        alloc_ok,
  input logic        last
);

  // An accepted allocate command always shows busy in the cycle after it is taken.
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (mode == mtt_pkg::MODE_ALLOC) |=> busy)
    else $error("allocate accepted without going busy");

  a_alloc_single: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == mtt_pkg::KIND_ALLOC) |-> last)
    else $error("allocation answer not marked last");

  a_alloc_fail: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == mtt_pkg::KIND_ALLOC) && !alloc_ok |-> (entry == 5'd0))
    else $error("failed allocation reports a nonzero entry");

  a_event_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == mtt_pkg::KIND_EXPIRY) |-> !alloc_ok)
    else $error("expiry event with alloc_ok set");

  // More events still to come: the scan must still be running.
  a_event_more: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == mtt_pkg::KIND_EXPIRY) && !last |-> busy)
    else $error("non-final expiry event while idle");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .mode     (mode),
  .busy     (busy),
  .strobe   (strobe),
  .kind     (kind),
  .entry    (entry),
  .alloc_ok (alloc_ok),
  .last     (last)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_timer_table. A predictor of the timer table
// (entry status, deadlines, data, tick count, earliest deadline) builds the
// allocation answers and expiry events that every command transaction causes.
// A monitor compares each strobed result with the oldest one still awaited.
// Directed corner cases come first, then a full table that expires on a
// single tick, then paced random traffic built mostly from timer lifecycles.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_TIMERS   = 32;
  localparam int RANDOM_ITEMS = 120;
  localparam int TAIL_CYCLES  = NUM_TIMERS + 8;

  localparam logic [2:0] MODE_RESERVED_LO = 3'd5;
  localparam logic [2:0] MODE_RESERVED_HI = 3'd7;

  typedef enum logic [1:0] {
    SLOT_UNUSED,
    SLOT_ALLOCATED,
    SLOT_RUNNING
  } slot_state_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] entry;
    logic       alloc_ok;
    logic [7:0] event_data;
    logic [3:0] event_channel;
    logic       last;
  } timer_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic [2:0]  mode;
  logic [4:0]  timer_index;
  logic [31:0] timeout;
  logic [7:0]  payload;
  logic [3:0]  channel;
  logic        busy;
  logic        strobe;
  logic        kind;
  logic [4:0]  entry;
  logic        alloc_ok;
  logic [7:0]  event_data;
  logic [3:0]  event_channel;
  logic        last;

  multi_timer_table #(
    .NUM_TIMERS(NUM_TIMERS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .mode(mode),
    .timer_index(timer_index),
    .timeout(timeout),
    .payload(payload),
    .channel(channel),
    .busy(busy),
    .strobe(strobe),
    .kind(kind),
    .entry(entry),
    .alloc_ok(alloc_ok),
    .event_data(event_data),
    .event_channel(event_channel),
    .last(last)
  );

  // Predicted timer table
  slot_state_t slot_state    [NUM_TIMERS];
  logic [31:0] slot_deadline [NUM_TIMERS];
  logic [7:0]  slot_payload  [NUM_TIMERS];
  logic [3:0]  slot_channel  [NUM_TIMERS];
  bit          slot_loaded   [NUM_TIMERS];
  logic [31:0] tick_total;
  logic [31:0] next_deadline;
  bit          grant_ok;
  logic [4:0]  grant_entry;

  timer_result_t expected_timer_results[$];

  int error_count;
  int commands_sent;
  int commands_ignored;
  int answers_seen;
  int expiries_seen;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still awaited", expected_timer_results.size());
    $display("multi_timer_table regression: fail");
    $finish;
  end

  // Update the predicted table for one accepted command and queue its results.
  task automatic compute_table_response(input logic [2:0] cmd_mode, input logic [4:0] idx,
                                        input logic [31:0] tmo, input logic [7:0] data,
                                        input logic [3:0] chan);
    timer_result_t res;
    logic [31:0]   due;
    int            fired;
    int            i;
    res   = '0;
    fired = 0;
    case (cmd_mode)
      mtt_pkg::MODE_TICK: begin
        tick_total = tick_total + 32'd1;
        if (next_deadline <= tick_total) begin
          next_deadline = mtt_pkg::NO_DEADLINE;
          for (i = 0; i < NUM_TIMERS; i++) begin
            if (slot_state[i] == SLOT_RUNNING) begin
              if (slot_deadline[i] <= tick_total && fired < mtt_pkg::MAX_RESULTS) begin
                slot_state[i]     = SLOT_ALLOCATED;
                res.kind          = mtt_pkg::KIND_EXPIRY;
                res.entry         = i[4:0];
                res.alloc_ok      = 1'b0;
                res.event_data    = slot_payload[i];
                res.event_channel = slot_channel[i];
                res.last          = 1'b0;
                expected_timer_results.push_back(res);
                fired++;
              end else if (slot_deadline[i] < next_deadline) begin
                next_deadline = slot_deadline[i];
              end
            end
          end
          if (fired > 0) begin
            res      = expected_timer_results.pop_back();
            res.last = 1'b1;
            expected_timer_results.push_back(res);
          end
        end
      end
      mtt_pkg::MODE_ALLOC: begin
        grant_ok    = 1'b0;
        grant_entry = '0;
        for (i = 0; i < NUM_TIMERS && !grant_ok; i++) begin
          if (slot_state[i] == SLOT_UNUSED) begin
            grant_ok      = 1'b1;
            grant_entry   = i[4:0];
            slot_state[i] = SLOT_ALLOCATED;
          end
        end
        res.kind     = mtt_pkg::KIND_ALLOC;
        res.entry    = grant_entry;
        res.alloc_ok = grant_ok;
        res.last     = 1'b1;
        expected_timer_results.push_back(res);
      end
      mtt_pkg::MODE_FREE: begin
        slot_state[idx] = SLOT_UNUSED;
      end
      mtt_pkg::MODE_INIT: begin
        slot_payload[idx] = data;
        slot_channel[idx] = chan;
        slot_loaded[idx]  = 1'b1;
      end
      mtt_pkg::MODE_SET: begin
        due                = tmo + tick_total;
        slot_deadline[idx] = due;
        slot_state[idx]    = SLOT_RUNNING;
        if (due < next_deadline) next_deadline = due;
      end
      default: begin
      end
    endcase
  endtask

  // Drive one command from a falling edge, hold it until taken, return on the
  // next falling edge with start still high.
  task automatic send_command(input logic [2:0] cmd_mode, input logic [4:0] idx,
                              input logic [31:0] tmo, input logic [7:0] data,
                              input logic [3:0] chan);
    start       <= 1'b1;
    mode        <= cmd_mode;
    timer_index <= idx;
    timeout     <= tmo;
    payload     <= data;
    channel     <= chan;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    compute_table_response(cmd_mode, idx, tmo, data, chan);
    if (cmd_mode > mtt_pkg::MODE_SET) commands_ignored++;
    else commands_sent++;
    @(negedge clk);
  endtask

  task automatic issue_tick;
    send_command(mtt_pkg::MODE_TICK, 5'($urandom), $urandom(), 8'($urandom),
                 4'($urandom));
  endtask

  task automatic issue_alloc;
    send_command(mtt_pkg::MODE_ALLOC, 5'($urandom), $urandom(), 8'($urandom),
                 4'($urandom));
  endtask

  task automatic issue_free(input logic [4:0] idx);
    send_command(mtt_pkg::MODE_FREE, idx, $urandom(), 8'($urandom), 4'($urandom));
  endtask

  task automatic issue_init(input logic [4:0] idx, input logic [7:0] data,
                            input logic [3:0] chan);
    send_command(mtt_pkg::MODE_INIT, idx, $urandom(), data, chan);
  endtask

  task automatic issue_set(input logic [4:0] idx, input logic [31:0] tmo);
    send_command(mtt_pkg::MODE_SET, idx, tmo, 8'($urandom), 4'($urandom));
  endtask

  // Drop start and hold off until every awaited result has come out.
  task automatic wait_for_results;
    start <= 1'b0;
    do @(negedge clk); while (expected_timer_results.size() != 0);
  endtask

  function automatic logic [31:0] pick_timeout();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel <= 5) return 32'($urandom_range(12, 0));
    if (sel <= 7) return 32'($urandom_range(60, 13));
    if (sel == 8) return $urandom();
    // wraps to just behind the count, so it fires on the next tick
    return 32'hffff_ffff - 32'($urandom_range(3, 0));
  endfunction

  task automatic test_directed_cases;
    send_command(MODE_RESERVED_LO, 5'd31, 32'hffff_ffff, 8'hff, 4'hf);
    issue_alloc();
    issue_alloc();
    issue_init(5'd0, 8'hff, 4'hf);
    issue_init(5'd1, 8'h00, 4'h0);
    issue_set(5'd0, 32'd0);
    issue_tick();
    issue_set(5'd1, 32'd3);
    issue_set(5'd0, 32'd3);
    repeat (3) issue_tick();
    // largest timeout wraps to count - 1
    issue_set(5'd0, 32'hffff_ffff);
    issue_tick();
    // earliest deadline reached with nothing left running
    issue_set(5'd1, 32'd2);
    issue_free(5'd1);
    repeat (2) issue_tick();
    issue_alloc();
    // arm an entry that was never allocated
    issue_init(5'd5, 8'ha5, 4'h5);
    issue_set(5'd5, 32'd1);
    issue_tick();
    issue_alloc();
    issue_free(5'd0);
    issue_free(5'd1);
    issue_free(5'd2);
    issue_free(5'd5);
    wait_for_results();
  endtask

  task automatic test_full_table;
    int i;
    for (i = 0; i < NUM_TIMERS; i++) issue_alloc();
    issue_alloc();
    for (i = 0; i < NUM_TIMERS; i++) issue_init(i[4:0], 8'($urandom), 4'($urandom));
    for (i = 0; i < NUM_TIMERS; i++) issue_set(i[4:0], 32'd1);
    // every entry fires on this one tick
    issue_tick();
    issue_alloc();
    for (i = 0; i < NUM_TIMERS; i++) issue_free(i[4:0]);
    wait_for_results();
  endtask

  task automatic test_random_traffic;
    int         pick;
    int         issued;
    bit         paused;
    logic [4:0] idx;
    issued     = 0;
    paused     = 1'b0;
    burst_left = 0;
    while (issued < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(16, 1);
        if ($urandom_range(3, 0) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(8, 1)) @(negedge clk);
        end
      end
      burst_left--;
      if (!paused && issued >= RANDOM_ITEMS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      idx  = 5'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 35) begin
        issue_tick();
        issued++;
      end else if (pick < 50) begin
        // allocate, load and arm the granted entry
        issue_alloc();
        issued++;
        if (grant_ok) begin
          issue_init(grant_entry, 8'($urandom), 4'($urandom));
          issue_set(grant_entry, pick_timeout());
          issued += 2;
        end
      end else if (pick < 65) begin
        issue_free(idx);
        issued++;
      end else if (pick < 75) begin
        issue_init(idx, 8'($urandom), 4'($urandom));
        issued++;
      end else if (pick < 88) begin
        // never arm an entry whose data was never loaded
        if (slot_loaded[idx]) issue_set(idx, pick_timeout());
        else issue_init(idx, 8'($urandom), 4'($urandom));
        issued++;
      end else if (pick < 93) begin
        issue_alloc();
        issued++;
      end else begin
        send_command(3'($urandom_range(MODE_RESERVED_HI, MODE_RESERVED_LO)), idx,
                     $urandom(), 8'($urandom), 4'($urandom));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && strobe === 1'b1) begin
      if (expected_timer_results.size() == 0) begin
        $error("unexpected result: kind %0h entry %0h", kind, entry);
        error_count++;
      end else begin
        want = expected_timer_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("entry", 32'(want.entry), 32'(entry));
        check_field("alloc_ok", 32'(want.alloc_ok), 32'(alloc_ok));
        check_field("event_data", 32'(want.event_data), 32'(event_data));
        check_field("event_channel", 32'(want.event_channel), 32'(event_channel));
        check_field("last", 32'(want.last), 32'(last));
      end
      if (kind === mtt_pkg::KIND_ALLOC) answers_seen++;
      else expiries_seen++;
    end
  end

  initial begin
    int i;
    rst         = 1'b1;
    start       = 1'b0;
    mode        = mtt_pkg::MODE_TICK;
    timer_index = '0;
    timeout     = '0;
    payload     = '0;
    channel     = '0;
    for (i = 0; i < NUM_TIMERS; i++) begin
      slot_state[i]    = SLOT_UNUSED;
      slot_deadline[i] = '0;
      slot_payload[i]  = '0;
      slot_channel[i]  = '0;
      slot_loaded[i]   = 1'b0;
    end
    tick_total       = '0;
    next_deadline    = mtt_pkg::NO_DEADLINE;
    grant_ok         = 1'b0;
    grant_entry      = '0;
    error_count      = 0;
    commands_sent    = 0;
    commands_ignored = 0;
    answers_seen     = 0;
    expiries_seen    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_table();
    test_random_traffic();

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Ran %0d table commands plus %0d reserved-mode transactions over %0d ticks.",
             commands_sent, commands_ignored, tick_total);
    $display("Checked %0d allocation answers and %0d expiry events, %0d mismatches.",
             answers_seen, expiries_seen, error_count);
    if (error_count == 0) begin
      $display("multi_timer_table regression: pass");
    end else begin
      $display("multi_timer_table regression: fail");
    end
    $finish;
  end

endmodule
